/* rtl/dclp_pkg.sv */
// dclp_pkg: shared types, constants and helper functions of the normal-diff
// command line parser. No dependencies.
package dclp_pkg;

    localparam int NUM_BITS = 32;            // signed width of one parsed number
    localparam int OUT_BITS = 32;            // width of the number fields on the ports
    localparam int WIDE_BITS = NUM_BITS + 4; // room for acc * 10 + digit

    localparam int Q_DEPTH = 4;
    localparam int Q_AW = $clog2(Q_DEPTH);
    localparam int Q_CW = $clog2(Q_DEPTH + 1);

    typedef logic [NUM_BITS-1:0] num_t;

    // saturation limit of the magnitude: 2^(NUM_BITS-1)
    localparam num_t MAG_CAP = num_t'(1) << (NUM_BITS - 1);

    typedef enum logic [1:0] {
        CMD_ADD    = 2'd0,
        CMD_CHANGE = 2'd1,
        CMD_DELETE = 2'd2
    } cmd_t;

    typedef enum logic [3:0] {
        CL_DIGIT,
        CL_SPACE,
        CL_PLUS,
        CL_MINUS,
        CL_COMMA,
        CL_CMD_A,
        CL_CMD_C,
        CL_CMD_D,
        CL_OTHER
    } cls_t;

    // which of the four numbers is being parsed
    typedef enum logic [1:0] {
        NUM_B1,
        NUM_B2,
        NUM_A1,
        NUM_A2
    } num_sel_t;

    // position inside one number
    typedef enum logic [1:0] {
        SUB_WS,
        SUB_SG,
        SUB_DG
    } sub_t;

    typedef struct packed {
        cls_t       cls;
        logic [3:0] digit;
        logic       line_end;
    } item_t;

    // line state captured at line end, finished by the output stage
    typedef struct packed {
        logic ok_pre;
        logic use_a2;
        num_t acc;
        logic neg;
        num_t hbf;
        num_t hbl;
        cmd_t cmd;
        num_t haf;
    } snap_t;

    // saturated signed value of a magnitude and sign
    function automatic num_t number_value(num_t acc, logic neg);
        num_t res;
        if (neg)
        begin
            res = ~acc + num_t'(1);
        end
        else if (acc == MAG_CAP)
        begin
            res = MAG_CAP - num_t'(1);
        end
        else
        begin
            res = acc;
        end
        return res;
    endfunction

    function automatic logic [OUT_BITS-1:0] to_out(num_t v);
        return OUT_BITS'($signed(v));
    endfunction

endpackage

/* rtl/dclp_front.sv */
// dclp_front: input side, accepts characters and sorts them into classes.
// Depends on dclp_pkg.
module dclp_front (
    input  logic              in_valid,
    output logic              in_stall,
    input  logic [7:0]        ch,
    input  logic              line_end,
    input  logic              q_full,
    output logic              push,
    output dclp_pkg::item_t   item
);
    import dclp_pkg::*;

    assign in_stall = q_full;
    assign push     = in_valid && !q_full;

    always_comb
    begin
        item.digit    = ch[3:0];
        item.line_end = line_end;
        if (ch >= 8'h30 && ch <= 8'h39)
        begin
            item.cls = CL_DIGIT;
        end
        else if (ch == 8'h20 || (ch >= 8'h09 && ch <= 8'h0d))
        begin
            item.cls = CL_SPACE;
        end
        else if (ch == 8'h2b)
        begin
            item.cls = CL_PLUS;
        end
        else if (ch == 8'h2d)
        begin
            item.cls = CL_MINUS;
        end
        else if (ch == 8'h2c)
        begin
            item.cls = CL_COMMA;
        end
        else if (ch == 8'h61)
        begin
            item.cls = CL_CMD_A;
        end
        else if (ch == 8'h63)
        begin
            item.cls = CL_CMD_C;
        end
        else if (ch == 8'h64)
        begin
            item.cls = CL_CMD_D;
        end
        else
        begin
            item.cls = CL_OTHER;
        end
    end

endmodule

/* rtl/dclp_queue.sv */
// dclp_queue: short FIFO of classified characters between front and back.
// Depends on dclp_pkg.
module dclp_queue (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  dclp_pkg::item_t   push_item,
    output logic              full,
    input  logic              pop,
    output logic              head_valid,
    output dclp_pkg::item_t   head
);
    import dclp_pkg::*;

    item_t             mem_reg [Q_DEPTH];
    logic [Q_AW-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [Q_AW-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [Q_CW-1:0]   count_reg, count_next;
    logic              do_pop;

    assign full       = (count_reg == Q_CW'(Q_DEPTH));
    assign head_valid = (count_reg != '0);
    assign head       = mem_reg[rd_ptr_reg];
    assign do_pop     = pop && head_valid;

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + Q_AW'(1) : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + Q_AW'(1) : rd_ptr_reg;
        count_next  = count_reg + Q_CW'(push) - Q_CW'(do_pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

/* rtl/dclp_back.sv */
// dclp_back: parse state machine, line-end capture and output register.
// Depends on dclp_pkg.
module dclp_back (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          head_valid,
    input  dclp_pkg::item_t               head,
    output logic                          pop,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic                          ok,
    output logic [dclp_pkg::OUT_BITS-1:0] before_first,
    output logic [dclp_pkg::OUT_BITS-1:0] before_last,
    output logic [1:0]                    command,
    output logic [dclp_pkg::OUT_BITS-1:0] after_first,
    output logic [dclp_pkg::OUT_BITS-1:0] after_last
);
    import dclp_pkg::*;

    // parse state
    num_sel_t num_reg, num_next, st_num;
    sub_t     sub_reg, sub_next, st_sub;
    logic     failed_reg, failed_next, st_failed;
    num_t     acc_reg, acc_next, st_acc;
    logic     neg_reg, neg_next, st_neg;
    num_t     hbf_reg, hbf_next, st_hbf;
    num_t     hbl_reg, hbl_next, st_hbl;
    cmd_t     cmd_reg, cmd_next, st_cmd;
    num_t     haf_reg, haf_next, st_haf;

    // line-end capture and output stage
    snap_t    snap_reg, snap_next;
    logic     snap_valid_reg, snap_valid_next;
    logic     out_valid_reg, out_valid_next;
    logic     ok_reg, ok_next;
    logic [OUT_BITS-1:0] bf_reg, bf_next, bl_reg, bl_next;
    logic [OUT_BITS-1:0] af_reg, af_next, al_reg, al_next;
    logic [1:0] cmd_out_reg, cmd_out_next;

    logic [WIDE_BITS-1:0] prod;
    logic                 sat;
    num_t                 cur_value;
    logic                 cmd_due;
    logic                 out_free, snap_move, snap_free;
    num_t                 res_v, res_a1;
    logic                 res_ok;

    assign out_free  = !out_valid_reg || !out_stall;
    assign snap_move = snap_valid_reg && out_free;
    assign snap_free = !snap_valid_reg || snap_move;
    assign pop       = head_valid && (!head.line_end || snap_free);

    // acc * 10 + digit, saturating at the magnitude cap
    assign prod = (WIDE_BITS'(acc_reg) << 3) + (WIDE_BITS'(acc_reg) << 1)
                  + WIDE_BITS'(head.digit);
    assign sat       = prod > WIDE_BITS'(MAG_CAP);
    assign cur_value = number_value(acc_reg, neg_reg);

    // one character step
    always_comb
    begin
        st_num    = num_reg;
        st_sub    = sub_reg;
        st_failed = failed_reg;
        st_acc    = acc_reg;
        st_neg    = neg_reg;
        st_hbf    = hbf_reg;
        st_hbl    = hbl_reg;
        st_cmd    = cmd_reg;
        st_haf    = haf_reg;
        cmd_due   = 1'b0;
        if (!failed_reg)
        begin
            if (head.cls == CL_DIGIT)
            begin
                st_acc = sat ? MAG_CAP : prod[NUM_BITS-1:0];
                st_sub = SUB_DG;
            end
            else
            begin
                unique case (sub_reg)
                    SUB_WS:
                    begin
                        if (head.cls == CL_PLUS || head.cls == CL_MINUS)
                        begin
                            st_neg = (head.cls == CL_MINUS);
                            st_sub = SUB_SG;
                        end
                        else if (head.cls != CL_SPACE)
                        begin
                            st_failed = 1'b1;
                        end
                    end
                    SUB_DG:
                    begin
                        unique case (num_reg)
                            NUM_B1:
                            begin
                                st_hbf = cur_value;
                                if (head.cls == CL_COMMA)
                                begin
                                    st_num = NUM_B2;
                                    st_sub = SUB_WS;
                                    st_acc = '0;
                                    st_neg = 1'b0;
                                end
                                else
                                begin
                                    st_hbl  = cur_value;
                                    cmd_due = 1'b1;
                                end
                            end
                            NUM_B2:
                            begin
                                st_hbl  = cur_value;
                                cmd_due = 1'b1;
                            end
                            NUM_A1:
                            begin
                                st_haf = cur_value;
                                if (head.cls == CL_COMMA)
                                begin
                                    st_num = NUM_A2;
                                    st_sub = SUB_WS;
                                    st_acc = '0;
                                    st_neg = 1'b0;
                                end
                                else
                                begin
                                    st_failed = 1'b1;
                                end
                            end
                            default:
                            begin
                                // junk after the last number
                                st_failed = 1'b1;
                            end
                        endcase
                        if (cmd_due)
                        begin
                            st_num = NUM_A1;
                            st_sub = SUB_WS;
                            st_acc = '0;
                            st_neg = 1'b0;
                            unique case (head.cls)
                                CL_CMD_A: st_cmd = CMD_ADD;
                                CL_CMD_C: st_cmd = CMD_CHANGE;
                                CL_CMD_D: st_cmd = CMD_DELETE;
                                default:  st_failed = 1'b1;
                            endcase
                        end
                    end
                    default:
                    begin
                        // non-digit right after a sign
                        st_failed = 1'b1;
                    end
                endcase
            end
        end
    end

    // next state: apply the step, capture and restart at line end
    always_comb
    begin
        num_next        = num_reg;
        sub_next        = sub_reg;
        failed_next     = failed_reg;
        acc_next        = acc_reg;
        neg_next        = neg_reg;
        hbf_next        = hbf_reg;
        hbl_next        = hbl_reg;
        cmd_next        = cmd_reg;
        haf_next        = haf_reg;
        snap_next       = snap_reg;
        snap_valid_next = snap_move ? 1'b0 : snap_valid_reg;
        if (pop)
        begin
            num_next    = st_num;
            sub_next    = st_sub;
            failed_next = st_failed;
            acc_next    = st_acc;
            neg_next    = st_neg;
            hbf_next    = st_hbf;
            hbl_next    = st_hbl;
            cmd_next    = st_cmd;
            haf_next    = st_haf;
            if (head.line_end)
            begin
                snap_next.ok_pre = !st_failed && (st_sub == SUB_DG)
                                   && (st_num == NUM_A1 || st_num == NUM_A2);
                snap_next.use_a2 = (st_num == NUM_A2);
                snap_next.acc    = st_acc;
                snap_next.neg    = st_neg;
                snap_next.hbf    = st_hbf;
                snap_next.hbl    = st_hbl;
                snap_next.cmd    = st_cmd;
                snap_next.haf    = st_haf;
                snap_valid_next  = 1'b1;
                num_next         = NUM_B1;
                sub_next         = SUB_WS;
                failed_next      = 1'b0;
                acc_next         = '0;
                neg_next         = 1'b0;
            end
        end
    end

    // result of a captured line
    always_comb
    begin
        res_v  = number_value(snap_reg.acc, snap_reg.neg);
        res_a1 = snap_reg.use_a2 ? snap_reg.haf : res_v;
        res_ok = snap_reg.ok_pre
                 && !(snap_reg.cmd == CMD_ADD && snap_reg.hbf != snap_reg.hbl)
                 && !(snap_reg.cmd == CMD_DELETE && res_a1 != res_v);
        out_valid_next = out_free ? snap_valid_reg : out_valid_reg;
        ok_next        = ok_reg;
        bf_next        = bf_reg;
        bl_next        = bl_reg;
        cmd_out_next   = cmd_out_reg;
        af_next        = af_reg;
        al_next        = al_reg;
        if (snap_move)
        begin
            ok_next      = res_ok;
            bf_next      = res_ok ? to_out(snap_reg.hbf) : '0;
            bl_next      = res_ok ? to_out(snap_reg.hbl) : '0;
            cmd_out_next = res_ok ? snap_reg.cmd : CMD_ADD;
            af_next      = res_ok ? to_out(res_a1) : '0;
            al_next      = res_ok ? to_out(res_v) : '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            num_reg        <= NUM_B1;
            sub_reg        <= SUB_WS;
            failed_reg     <= 1'b0;
            acc_reg        <= '0;
            neg_reg        <= 1'b0;
            hbf_reg        <= '0;
            hbl_reg        <= '0;
            cmd_reg        <= CMD_ADD;
            haf_reg        <= '0;
            snap_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            num_reg        <= num_next;
            sub_reg        <= sub_next;
            failed_reg     <= failed_next;
            acc_reg        <= acc_next;
            neg_reg        <= neg_next;
            hbf_reg        <= hbf_next;
            hbl_reg        <= hbl_next;
            cmd_reg        <= cmd_next;
            haf_reg        <= haf_next;
            snap_valid_reg <= snap_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        snap_reg    <= snap_next;
        ok_reg      <= ok_next;
        bf_reg      <= bf_next;
        bl_reg      <= bl_next;
        cmd_out_reg <= cmd_out_next;
        af_reg      <= af_next;
        al_reg      <= al_next;
    end

    assign out_valid    = out_valid_reg;
    assign ok           = ok_reg;
    assign before_first = bf_reg;
    assign before_last  = bl_reg;
    assign command      = cmd_out_reg;
    assign after_first  = af_reg;
    assign after_last   = al_reg;

endmodule

/* rtl/diff_command_line_parser_core.sv */
// diff_command_line_parser_core: top level of the normal-diff command parser.
// Depends on dclp_pkg, dclp_front, dclp_queue, dclp_back.
//
//  channel | handshake           | payload
//  --------+---------------------+----------------------------------------------
//  in      | in_valid / in_stall | ch, line_end
//  out     | out_valid/out_stall | ok, before_first, before_last, command,
//          |                     | after_first, after_last
//
// One character per cycle sustained unless the queue is full; the back end retires
// one queued character per cycle with a single multiply-by-ten-and-add, unless a
// line end waits for a free capture register. The result is registered.
// in_stall rises only when the 4-entry character queue is full.
// out_stall holds the result; characters keep flowing until a second captured
// line waits behind it and the next line end reaches the queue head.
// rst_n is asynchronous; no clearing pass.
module diff_command_line_parser_core (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [7:0]                    ch,
    input  logic                          line_end,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic                          ok,
    output logic [dclp_pkg::OUT_BITS-1:0] before_first,
    output logic [dclp_pkg::OUT_BITS-1:0] before_last,
    output logic [1:0]                    command,
    output logic [dclp_pkg::OUT_BITS-1:0] after_first,
    output logic [dclp_pkg::OUT_BITS-1:0] after_last
);
    import dclp_pkg::*;

    item_t push_item;
    item_t head;
    logic  push;
    logic  q_full;
    logic  head_valid;
    logic  pop;

    dclp_front u_front (
        .in_valid (in_valid),
        .in_stall (in_stall),
        .ch       (ch),
        .line_end (line_end),
        .q_full   (q_full),
        .push     (push),
        .item     (push_item)
    );

    dclp_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_item  (push_item),
        .full       (q_full),
        .pop        (pop),
        .head_valid (head_valid),
        .head       (head)
    );

    dclp_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .head_valid   (head_valid),
        .head         (head),
        .pop          (pop),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .ok           (ok),
        .before_first (before_first),
        .before_last  (before_last),
        .command      (command),
        .after_first  (after_first),
        .after_last   (after_last)
    );

endmodule

/* rtl/dclp_checker.sv */
// dclp_checker: port-level assertions for diff_command_line_parser_core,
// bound to the top level below. Depends on dclp_pkg.
module dclp_checker (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          in_valid,
    input logic                          in_stall,
    input logic [7:0]                    ch,
    input logic                          line_end,
    input logic                          out_valid,
    input logic                          out_stall,
    input logic                          ok,
    input logic [dclp_pkg::OUT_BITS-1:0] before_first,
    input logic [dclp_pkg::OUT_BITS-1:0] before_last,
    input logic [1:0]                    command,
    input logic [dclp_pkg::OUT_BITS-1:0] after_first,
    input logic [dclp_pkg::OUT_BITS-1:0] after_last
);
    import dclp_pkg::*;

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(ok)
            && $stable(before_first) && $stable(after_last))
        else $error("stalled result changed");

    a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !ok |-> before_first == '0 && before_last == '0
            && command == CMD_ADD && after_first == '0 && after_last == '0)
        else $error("failed line carries nonzero fields");

    a_cmd_code: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && ok |-> command == CMD_ADD || command == CMD_CHANGE
            || command == CMD_DELETE)
        else $error("undefined command code");

    a_add_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && ok && command == CMD_ADD |-> before_first == before_last)
        else $error("add with a before range");

    a_del_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && ok && command == CMD_DELETE |-> after_first == after_last)
        else $error("delete with an after range");

endmodule

bind diff_command_line_parser_core dclp_checker u_dclp_checker (.*);

/* dv/dclp_line_checker.sv */
`timescale 1ns / 1ps
// dclp_line_checker: watches both channels of diff_command_line_parser_core, predicts the
// result of every command line from its characters and compares it with the block's output.
// Depends on dclp_pkg.
module dclp_line_checker
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    input  logic                          in_stall,
    input  logic [7:0]                    ch,
    input  logic                          line_end,
    input  logic                          out_valid,
    input  logic                          out_stall,
    input  logic                          ok,
    input  logic [dclp_pkg::OUT_BITS-1:0] before_first,
    input  logic [dclp_pkg::OUT_BITS-1:0] before_last,
    input  logic [1:0]                    command,
    input  logic [dclp_pkg::OUT_BITS-1:0] after_first,
    input  logic [dclp_pkg::OUT_BITS-1:0] after_last,
    output int                            fail_count,
    output int                            lines_pending
);

    import dclp_pkg::*;

    // magnitude limit 2^(NUM_BITS-1), kept wide so acc * 10 + digit never wraps
    localparam logic [63:0] SAT_MAG = 64'd1 << (NUM_BITS - 1);

    localparam logic [7:0] CH_PLUS   = "+";
    localparam logic [7:0] CH_MINUS  = "-";
    localparam logic [7:0] CH_COMMA  = ",";
    localparam logic [7:0] CH_ZERO   = "0";
    localparam logic [7:0] CH_NINE   = "9";
    localparam logic [7:0] CH_SPACE  = " ";
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_CR     = 8'h0D;

    localparam logic [7:0] LETTER_ADD    = "a";
    localparam logic [7:0] LETTER_CHANGE = "c";
    localparam logic [7:0] LETTER_DELETE = "d";

    typedef struct packed {
        logic                ok;
        logic [OUT_BITS-1:0] before_first;
        logic [OUT_BITS-1:0] before_last;
        cmd_t                command;
        logic [OUT_BITS-1:0] after_first;
        logic [OUT_BITS-1:0] after_last;
    } line_result_t;

    line_result_t expected_lines[$];

    // parse state of the line in progress
    num_sel_t    cur_num;
    sub_t        cur_sub;
    logic [63:0] mag;
    logic        neg;
    logic        failed;
    num_t        hold_bf;
    num_t        hold_bl;
    num_t        hold_af;
    cmd_t        hold_cmd;
    int          n_fail;

    function automatic logic is_blank(logic [7:0] c);
        return c == CH_SPACE || (c >= CH_TAB && c <= CH_CR);
    endfunction

    // strtol-style saturation of the magnitude and sign seen so far
    function automatic num_t parsed_value();
        logic [63:0] m;
        m = (mag > SAT_MAG) ? SAT_MAG : mag;
        if (neg)
        begin
            return num_t'(64'd0 - m);
        end
        return (m >= SAT_MAG) ? num_t'(SAT_MAG - 64'd1) : num_t'(m);
    endfunction

    task automatic open_number(num_sel_t which);
        cur_num = which;
        cur_sub = SUB_WS;
        mag     = '0;
        neg     = 1'b0;
    endtask

    task automatic clear_line();
        open_number(NUM_B1);
        failed   = 1'b0;
        hold_bf  = '0;
        hold_bl  = '0;
        hold_af  = '0;
        hold_cmd = CMD_ADD;
    endtask

    task automatic take_letter(logic [7:0] c);
        case (c)
            LETTER_ADD:    hold_cmd = CMD_ADD;
            LETTER_CHANGE: hold_cmd = CMD_CHANGE;
            LETTER_DELETE: hold_cmd = CMD_DELETE;
            default:       failed = 1'b1;
        endcase
        if (!failed)
            open_number(NUM_A1);
    endtask

    task automatic parse_char(logic [7:0] c);
        logic [63:0] d;
        num_t        v;
        if (c >= CH_ZERO && c <= CH_NINE)
        begin
            d = 64'(c - CH_ZERO);
            if (mag > (SAT_MAG - d) / 64'd10)
                mag = SAT_MAG;
            else
                mag = mag * 64'd10 + d;
            cur_sub = SUB_DG;
        end
        else if (cur_sub == SUB_WS)
        begin
            if (c == CH_PLUS || c == CH_MINUS)
            begin
                neg     = (c == CH_MINUS);
                cur_sub = SUB_SG;
            end
            else if (!is_blank(c))
            begin
                failed = 1'b1;
            end
        end
        else if (cur_sub == SUB_SG)
        begin
            failed = 1'b1;
        end
        else
        begin
            // a non-digit closes the current number
            v = parsed_value();
            case (cur_num)
                NUM_B1:
                begin
                    hold_bf = v;
                    if (c == CH_COMMA)
                    begin
                        open_number(NUM_B2);
                    end
                    else
                    begin
                        hold_bl = v;
                        take_letter(c);
                    end
                end
                NUM_B2:
                begin
                    hold_bl = v;
                    take_letter(c);
                end
                NUM_A1:
                begin
                    hold_af = v;
                    if (c == CH_COMMA)
                        open_number(NUM_A2);
                    else
                        failed = 1'b1;
                end
                default: failed = 1'b1;
            endcase
        end
    endtask

    task automatic finish_line();
        line_result_t r;
        num_t         a1;
        num_t         a2;
        r = '0;
        if (!failed && cur_sub == SUB_DG && (cur_num == NUM_A1 || cur_num == NUM_A2))
        begin
            a2 = parsed_value();
            a1 = (cur_num == NUM_A1) ? a2 : hold_af;
            if (!(hold_cmd == CMD_ADD && hold_bf != hold_bl) &&
                !(hold_cmd == CMD_DELETE && a1 != a2))
            begin
                r.ok           = 1'b1;
                r.before_first = hold_bf;
                r.before_last  = hold_bl;
                r.command      = hold_cmd;
                r.after_first  = a1;
                r.after_last   = a2;
            end
        end
        expected_lines = {expected_lines, r};
        clear_line();
    endtask

    task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
        if (got !== want)
        begin
            $error("%s: expected %0d, got %0d", name, $signed(want), $signed(got));
            n_fail++;
        end
    endtask

    task automatic check_result(line_result_t want);
        check_field("ok", 32'(want.ok), 32'(ok));
        check_field("before_first", want.before_first, before_first);
        check_field("before_last", want.before_last, before_last);
        check_field("command", 32'(want.command), 32'(command));
        check_field("after_first", want.after_first, after_first);
        check_field("after_last", want.after_last, after_last);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clear_line();
            expected_lines.delete();
            n_fail = 0;
            fail_count    <= 0;
            lines_pending <= 0;
        end
        else
        begin
            // results lag their line, so retire before predicting
            if (out_valid && !out_stall)
            begin
                if (expected_lines.size() == 0)
                begin
                    $error("result transaction with no line outstanding");
                    n_fail++;
                end
                else
                begin
                    check_result(expected_lines.pop_front());
                end
            end
            if (in_valid && !in_stall)
            begin
                if (!failed)
                    parse_char(ch);
                if (line_end)
                    finish_line();
            end
            fail_count    <= n_fail;
            lines_pending <= expected_lines.size();
        end
    end

endmodule

/* dv/tb_diff_command_line_parser_core.sv */
`timescale 1ns / 1ps
// tb_diff_command_line_parser_core: feeds directed and random normal-diff command lines to
// the parser with random gaps and output stalls; the verdict comes from dclp_line_checker.
// Depends on dclp_pkg, diff_command_line_parser_core and dclp_line_checker.
module tb_diff_command_line_parser_core;

    import dclp_pkg::*;

    localparam int    CHAR_BUDGET = 550;
    localparam int    CYCLE_LIMIT = 200000;
    localparam int    TAIL_CYCLES = 20;
    localparam string CMD_LETTERS = "acd";
    localparam string BLANKS      = " \011\012\013\014\015";

    logic                clk;
    logic                rst_n;
    logic                in_valid;
    logic                in_stall;
    logic [7:0]          ch;
    logic                line_end;
    logic                out_valid;
    logic                out_stall;
    logic                ok;
    logic [OUT_BITS-1:0] before_first;
    logic [OUT_BITS-1:0] before_last;
    logic [1:0]          command;
    logic [OUT_BITS-1:0] after_first;
    logic [OUT_BITS-1:0] after_last;

    int         fail_count;
    int         lines_pending;
    logic [7:0] line_buf[$];
    int         chars_sent = 0;
    int         cycles = 0;
    bit         steady = 1'b0;
    bit         paused = 1'b0;
    int         rx_hold;
    int         rx_roll;
    bit         rx_busy;

    diff_command_line_parser_core u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .ch           (ch),
        .line_end     (line_end),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .ok           (ok),
        .before_first (before_first),
        .before_last  (before_last),
        .command      (command),
        .after_first  (after_first),
        .after_last   (after_last)
    );

    dclp_line_checker u_check (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .ch            (ch),
        .line_end      (line_end),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .ok            (ok),
        .before_first  (before_first),
        .before_last   (before_last),
        .command       (command),
        .after_first   (after_first),
        .after_last    (after_last),
        .fail_count    (fail_count),
        .lines_pending (lines_pending)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT)
        begin
            $display("diff_command_line_parser_core regression: fail");
            $finish;
        end
    end

    // receiver: mostly ready, short stalls, the odd long one
    initial
    begin
        out_stall = 1'b0;
        rx_hold   = 0;
        rx_busy   = 1'b0;
        forever
        begin
            @(negedge clk);
            if (rx_hold > 0)
            begin
                rx_hold--;
            end
            else
            begin
                rx_roll = $urandom_range(0, 99);
                if (rx_roll < 60)
                begin
                    rx_busy = 1'b0;
                    rx_hold = $urandom_range(0, 6);
                end
                else if (rx_roll < 94)
                begin
                    rx_busy = 1'b1;
                    rx_hold = $urandom_range(0, 2);
                end
                else
                begin
                    rx_busy = 1'b1;
                    rx_hold = $urandom_range(8, 30);
                end
            end
            out_stall <= rx_busy && !steady;
        end
    end

    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 55)
            return 0;
        if (roll < 90)
            return $urandom_range(1, 3);
        if (roll < 98)
            return $urandom_range(4, 10);
        return $urandom_range(20, 40);
    endfunction

    task automatic send_char(logic [7:0] c, logic last);
        int gap;
        gap = steady ? 0 : pick_gap();
        repeat (gap)
        begin
            @(negedge clk);
            in_valid <= 1'b0;
        end
        @(negedge clk);
        in_valid <= 1'b1;
        ch       <= c;
        line_end <= last;
        do
            @(posedge clk);
        while (in_stall);
        chars_sent++;
    endtask

    task automatic append_char(logic [7:0] c);
        line_buf = {line_buf, c};
    endtask

    task automatic push_text(string s);
        for (int i = 0; i < s.len(); i++)
            append_char(s[i]);
    endtask

    // sends whatever is buffered plus the tail, marking the final character
    task automatic send_line(string tail);
        push_text(tail);
        for (int i = 0; i < line_buf.size(); i++)
            send_char(line_buf[i], i == line_buf.size() - 1);
        line_buf.delete();
    endtask

    task automatic drain();
        @(negedge clk);
        in_valid <= 1'b0;
        wait (lines_pending == 0);
    endtask

    task automatic push_digits(int n);
        repeat (n)
            append_char(8'("0") + 8'($urandom_range(0, 9)));
    endtask

    task automatic push_number();
        int roll;
        if ($urandom_range(0, 7) == 0)
        begin
            repeat ($urandom_range(1, 2))
                append_char(BLANKS[$urandom_range(0, BLANKS.len() - 1)]);
        end
        roll = $urandom_range(0, 7);
        if (roll == 0)
            append_char("+");
        else if (roll == 1)
            append_char("-");
        roll = $urandom_range(0, 19);
        if (roll == 0)
        begin
            case ($urandom_range(0, 2))
                0:       push_text("2147483647");
                1:       push_text("2147483648");
                default: push_text("2147483649");
            endcase
        end
        else if (roll == 1)
        begin
            push_digits($urandom_range(10, 14));
        end
        else
        begin
            push_digits($urandom_range(1, 3));
        end
    endtask

    task automatic copy_text(int from, int upto);
        for (int i = from; i < upto; i++)
            append_char(line_buf[i]);
    endtask

    // a first number and, optionally, a second: a copy of the first (equal value) or a fresh one
    task automatic push_range(bit want_equal);
        int mark;
        int stop;
        mark = line_buf.size();
        push_number();
        stop = line_buf.size();
        if ($urandom_range(0, 4) < 2)
        begin
            append_char(",");
            if (want_equal && $urandom_range(0, 3) != 0)
                copy_text(mark, stop);
            else
                push_number();
        end
    endtask

    task automatic build_random_line();
        int   kind;
        int   keep;
        cmd_t op;
        kind = $urandom_range(0, 19);
        if (kind == 0)
        begin
            repeat ($urandom_range(1, 6))
                append_char(8'($urandom_range(0, 255)));
            return;
        end
        op = cmd_t'($urandom_range(0, 2));
        push_range(op == CMD_ADD);
        append_char(CMD_LETTERS[op]);
        push_range(op == CMD_DELETE);
        if (kind <= 3)
        begin
            // broken line: corrupt, cut short or extend with junk
            case ($urandom_range(0, 2))
                0: line_buf[$urandom_range(0, line_buf.size() - 1)] = 8'($urandom_range(0, 255));
                1:
                begin
                    keep = $urandom_range(1, line_buf.size());
                    while (line_buf.size() > keep)
                        line_buf.delete(line_buf.size() - 1);
                end
                default:
                begin
                    repeat ($urandom_range(1, 2))
                        append_char(8'($urandom_range(0, 255)));
                end
            endcase
        end
    endtask

    initial
    begin
        rst_n    = 1'b0;
        in_valid = 1'b0;
        ch       = '0;
        line_end = 1'b0;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        send_line("3,5c7,9");
        send_line("5a6,8");
        send_line("3,5a7");
        send_line("3,4d2");
        send_line("3,4d2,3");
        send_line("2147483647c-2147483648,2147483648");
        send_line("99999999999,-99999999999c+0,-00");
        send_line(" \011+12,\012-3c\013 4,\014\015 5");
        send_line("12c");
        send_line("12");
        send_line("x");
        send_line("1c2x");
        send_line("1c2,3,4");
        push_text("1");
        append_char(8'h00);
        send_line("c2");
        push_text("1c");
        append_char(8'hFF);
        send_line("2");
        send_line("+c1");
        send_line("- 3c1");
        send_line(" 1 c2");
        send_line("1,c2");
        send_line("0,-0a-0");
        send_line("a1c2");
        drain();

        while (chars_sent < CHAR_BUDGET)
        begin
            steady = ($urandom_range(0, 7) == 0);
            build_random_line();
            send_line("");
            if (!paused && chars_sent >= CHAR_BUDGET / 2)
            begin
                drain();
                paused = 1'b1;
            end
        end
        steady = 1'b0;
        drain();
        repeat (TAIL_CYCLES) @(posedge clk);

        if (fail_count == 0)
            $display("diff_command_line_parser_core regression: pass");
        else
            $display("diff_command_line_parser_core regression: fail");
        $finish;
    end

endmodule

/* diff_command_line_parser_core.f */
rtl/dclp_pkg.sv
rtl/dclp_front.sv
rtl/dclp_queue.sv
rtl/dclp_back.sv
rtl/diff_command_line_parser_core.sv
rtl/dclp_checker.sv
dv/dclp_line_checker.sv
dv/tb_diff_command_line_parser_core.sv
